// File: rtl/ostl_pkg.sv
// Package for the ordered selection toggle list.
// Holds sizes, operation codes, the FSM state type and the memory request struct.
// No dependencies; used by ostl_mem and ordered_selection_toggle_list.
package ostl_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDENT_BITS = 17;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Fixed field widths of the item and result ports.
  localparam int MODE_W   = 2;
  localparam int IN_ID_W  = 17;
  localparam int RIDX_W   = 6;
  localparam int POS_W    = 7;
  localparam int OUT_ID_W = 17;
  localparam int OUT_CT_W = 7;

  localparam logic signed [POS_W-1:0] POS_NONE = -7'sd1;

  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [IDENT_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

// File: rtl/ostl_mem.sv
// List storage: one write port and one read port, read data registered.
// Depends on ostl_pkg for the depth, widths and the request struct.
module ostl_mem (
  input  logic                           clk,
  input  ostl_pkg::mem_req_t             req,
  output logic [ostl_pkg::IDENT_BITS-1:0] rdata
);

  logic [ostl_pkg::IDENT_BITS-1:0] mem [ostl_pkg::CAPACITY];
  logic [ostl_pkg::IDENT_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ordered_selection_toggle_list.sv
// Top level of the ordered selection toggle list: sequencer, count and result registers.
// Depends on ostl_pkg and instantiates ostl_mem for the list storage.
//
// Usage: an item (in_mode, in_ident, in_read_index) is taken at a rising edge where
// start is high and busy is low. Each item gives exactly one result, shown on the out_
// ports for a single cycle with out_strobe high; the receiver cannot stall it, so it
// must take the result in that cycle. The next item may be started in the same cycle
// that busy falls, even while the previous result is still on the out_ ports.
// Flow of each mode:
//   clear: empties the list without leaving idle (busy never rises).
//   read: the entry comes from one synchronous memory read.
//   lookup and toggle: the search reads one entry per cycle from the memory port,
//   pipelined against the compare, and ends at a hit or after the last entry.
//   A toggle that removes the entry at position p then moves the later entries down,
//   one read and one write per cycle. The worst toggle is therefore a removal from
//   the front, set by the single memory read port.
// Reset empties the list and returns to idle; stored entries are not cleared and are
// never read before they are written again.
module ordered_selection_toggle_list (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ostl_pkg::MODE_W-1:0]         in_mode,
  input  logic [ostl_pkg::IN_ID_W-1:0]        in_ident,
  input  logic [ostl_pkg::RIDX_W-1:0]         in_read_index,
  output logic                                out_strobe,
  output logic signed [ostl_pkg::POS_W-1:0]   out_found_pos,
  output logic                                out_removed,
  output logic                                out_appended,
  output logic                                out_overflow,
  output logic [ostl_pkg::OUT_ID_W-1:0]       out_entry_value,
  output logic                                out_entry_valid,
  output logic [ostl_pkg::OUT_CT_W-1:0]       out_count
);

  localparam int AW = ostl_pkg::ADDR_W;
  localparam int CW = ostl_pkg::CNT_W;
  localparam int IW = ostl_pkg::IDENT_BITS;

  // Control state.
  ostl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;         // next memory address to read
  logic             pend_r, pend_nxt;       // a read is in flight
  logic [AW-1:0]    pend_idx_r, pend_idx_nxt;

  // Item context.
  logic [ostl_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [IW-1:0]               id_r, id_nxt;
  logic                        rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;

  // Result registers.
  logic                                out_strobe_r;
  logic signed [ostl_pkg::POS_W-1:0]   out_found_pos_r;
  logic                                out_removed_r;
  logic                                out_appended_r;
  logic                                out_overflow_r;
  logic [ostl_pkg::OUT_ID_W-1:0]       out_entry_value_r;
  logic                                out_entry_valid_r;
  logic [ostl_pkg::OUT_CT_W-1:0]       out_count_r;

  // Result of the current cycle, loaded into the result registers when fin is high.
  logic                                fin;
  logic signed [ostl_pkg::POS_W-1:0]   res_pos;
  logic                                res_removed;
  logic                                res_appended;
  logic                                res_overflow;
  logic [ostl_pkg::OUT_ID_W-1:0]       res_value;
  logic                                res_valid;

  ostl_pkg::mem_req_t mem_req;
  logic [IW-1:0]      rdata;

  logic acc;
  logic hit;
  logic more;

  ostl_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign busy = (state_r != ostl_pkg::ST_IDLE);
  assign acc  = start && !busy;
  // The data of the entry read in the previous cycle matches the identifier.
  assign hit  = pend_r && (rdata == id_r);
  // Entries remain to be read for the search or the move-down.
  assign more = (idx_r < count_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ostl_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_mode) inside
            ostl_pkg::MODE_TOGGLE, ostl_pkg::MODE_LOOKUP: state_nxt = ostl_pkg::ST_SEARCH;
            ostl_pkg::MODE_READ:                          state_nxt = ostl_pkg::ST_READ;
            default:                                      state_nxt = ostl_pkg::ST_IDLE;
          endcase
        end
      end
      ostl_pkg::ST_SEARCH: begin
        if (hit) begin
          state_nxt = (mode_r == ostl_pkg::MODE_TOGGLE) ? ostl_pkg::ST_SHIFT
                                                        : ostl_pkg::ST_IDLE;
        end else if (!more) begin
          state_nxt = ostl_pkg::ST_IDLE;
        end
      end
      ostl_pkg::ST_SHIFT: begin
        if (!more && !pend_r) begin
          state_nxt = ostl_pkg::ST_IDLE;
        end
      end
      ostl_pkg::ST_READ: begin
        state_nxt = ostl_pkg::ST_IDLE;
      end
      default: state_nxt = ostl_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory requests and results.
  always_comb begin
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    mode_nxt     = mode_r;
    id_nxt       = id_r;
    rd_ok_nxt    = rd_ok_r;
    pos_nxt      = pos_r;

    mem_req         = '0;
    mem_req.wr_data = id_r;

    fin          = 1'b0;
    res_pos      = ostl_pkg::POS_NONE;
    res_removed  = 1'b0;
    res_appended = 1'b0;
    res_overflow = 1'b0;
    res_value    = '0;
    res_valid    = 1'b0;

    unique case (state_r)
      ostl_pkg::ST_IDLE: begin
        if (acc) begin
          mode_nxt = in_mode;
          id_nxt   = IW'(in_ident);
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          case (in_mode) inside
            ostl_pkg::MODE_READ: begin
              // The read is issued right away; only entries below the count are read.
              rd_ok_nxt       = (32'(in_read_index) < 32'(count_r));
              mem_req.rd_en   = rd_ok_nxt;
              mem_req.rd_addr = AW'(in_read_index);
            end
            ostl_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              fin       = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ostl_pkg::ST_SEARCH: begin
        if (hit) begin
          pos_nxt  = pend_idx_r;
          pend_nxt = 1'b0;
          if (mode_r == ostl_pkg::MODE_TOGGLE) begin
            // Start the move-down with the entry just behind the hit.
            idx_nxt = CW'(pend_idx_r) + CW'(1);
          end else begin
            fin     = 1'b1;
            res_pos = ostl_pkg::POS_W'(pend_idx_r);
          end
        end else if (more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[AW-1:0];
          pend_nxt        = 1'b1;
          pend_idx_nxt    = idx_r[AW-1:0];
          idx_nxt         = idx_r + CW'(1);
        end else begin
          // The identifier is absent: a toggle appends it unless the list is full.
          pend_nxt = 1'b0;
          fin      = 1'b1;
          if (mode_r == ostl_pkg::MODE_TOGGLE) begin
            if (count_r < CW'(ostl_pkg::CAPACITY)) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = count_r[AW-1:0];
              count_nxt       = count_r + CW'(1);
              res_appended    = 1'b1;
            end else begin
              res_overflow = 1'b1;
            end
          end
        end
      end

      ostl_pkg::ST_SHIFT: begin
        // The entry read last cycle goes one place down.
        if (pend_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pend_idx_r - AW'(1);
          mem_req.wr_data = rdata;
        end
        if (more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[AW-1:0];
          pend_nxt        = 1'b1;
          pend_idx_nxt    = idx_r[AW-1:0];
          idx_nxt         = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt   = count_r - CW'(1);
            fin         = 1'b1;
            res_pos     = ostl_pkg::POS_W'(pos_r);
            res_removed = 1'b1;
          end
        end
      end

      ostl_pkg::ST_READ: begin
        fin       = 1'b1;
        res_valid = rd_ok_r;
        res_value = rd_ok_r ? ostl_pkg::OUT_ID_W'(rdata) : '0;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ostl_pkg::ST_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    mode_r     <= mode_nxt;
    id_r       <= id_nxt;
    rd_ok_r    <= rd_ok_nxt;
    pos_r      <= pos_nxt;
    if (fin) begin
      out_found_pos_r   <= res_pos;
      out_removed_r     <= res_removed;
      out_appended_r    <= res_appended;
      out_overflow_r    <= res_overflow;
      out_entry_value_r <= res_value;
      out_entry_valid_r <= res_valid;
      out_count_r       <= ostl_pkg::OUT_CT_W'(count_nxt);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_found_pos   = out_found_pos_r;
  assign out_removed     = out_removed_r;
  assign out_appended    = out_appended_r;
  assign out_overflow    = out_overflow_r;
  assign out_entry_value = out_entry_value_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_count       = out_count_r;

`ifndef SYNTHESIS
  // The list never holds more entries than the storage.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ostl_pkg::CAPACITY))
    else $error("entry count above capacity");

  // During the move-down the write never hits the entry being read.
  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("memory read and write at the same entry");

  // An append grows the list by exactly one entry.
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_appended_r) |-> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not grow the count by one");

  // A result only follows an accepted item or work in progress.
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe_r) |-> ($past(busy) || $past(acc)))
    else $error("result without an item");
`endif

endmodule
